// File: hdl/hetm_pkg.sv
// shared types, constants and the slot hash of the half-edge twin matcher
`timescale 1ns / 1ps
`default_nettype none
package hetm_pkg;

  localparam int MAX_FACES   = 1024;
  localparam int VERTEX_BITS = 16;
  localparam int CORNER_BITS = 16;
  localparam int HE_BITS     = 12;
  localparam int OPP_BITS    = 13;
  localparam int EDGE_DEPTH  = 3 * MAX_FACES;
  localparam int SLOT_BITS   = $clog2(EDGE_DEPTH + 1);
  localparam int SLOTS       = 2 ** SLOT_BITS;
  localparam int KEY_BITS    = 2 * VERTEX_BITS;
  localparam int FC_BITS     = $clog2(MAX_FACES + 1);
  localparam int EPOCH_BITS  = 4;
  localparam int ENTRY_BITS  = EPOCH_BITS + KEY_BITS + HE_BITS;
  localparam int HASH_CHUNKS = (KEY_BITS + SLOT_BITS - 1) / SLOT_BITS;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [EPOCH_BITS-1:0]  epoch_t;
  typedef logic [HE_BITS-1:0]     he_t;

  typedef enum logic {
    OPP_NONE,
    OPP_OWNER
  } opp_sel_t;

  typedef struct packed {
    logic     load_face;
    logic     fc_clear;
    logic     fc_inc;
    logic     j_inc;
    logic     j_clear;
    logic     epoch_init;
    logic     epoch_inc;
    logic     addr_zero;
    logic     start_probe;
    logic     probe_fwd;
    logic     probe_next;
    logic     rd_en;
    logic     write_entry;
    logic     clear_write;
    logic     load_out;
    opp_sel_t opp_sel;
    logic     full_out;
  } hetm_cmd_t;

  typedef struct packed {
    logic entry_live;
    logic key_match;
    logic mode_fwd;
    logic last_j;
    logic fc_full;
    logic clear_done;
    logic epoch_max;
    logic out_free;
  } hetm_sts_t;

  function automatic slot_t hash_key(key_t k);
    logic [SLOT_BITS*HASH_CHUNKS-1:0] ext;
    slot_t h;
    ext = (SLOT_BITS*HASH_CHUNKS)'(k);
    h = '0;
    for (int i = 0; i < HASH_CHUNKS; i++) begin
      h = h ^ ext[i*SLOT_BITS +: SLOT_BITS];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hetm_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hetm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/hetm_dpath.sv
// datapath: face registers, hashed edge table, probe address and result register
`timescale 1ns / 1ps
`default_nettype none
module hetm_dpath
  import hetm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire hetm_cmd_t               cmd,
  output hetm_sts_t                    sts,
  input  wire logic [CORNER_BITS-1:0]  corner_a,
  input  wire logic [CORNER_BITS-1:0]  corner_b,
  input  wire logic [CORNER_BITS-1:0]  corner_c,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [HE_BITS-1:0]           half_edge_id,
  output logic signed [OPP_BITS-1:0]   opposite_id,
  output logic                         table_full,
  output logic                         last
);

  vertex_t va, vb, vc;
  logic [1:0] j;
  logic [FC_BITS-1:0] fc;
  epoch_t epoch;
  slot_t addr;
  key_t probe_key;
  logic mode_fwd;

  vertex_t src, tgt;
  key_t key_sel;
  he_t he;
  logic [ENTRY_BITS-1:0] wdata, rdata;
  epoch_t rd_epoch;
  key_t rd_key;
  he_t rd_owner;

  always_comb begin
    unique case (j)
      2'd0: begin src = vb; tgt = vc; end
      2'd1: begin src = vc; tgt = va; end
      default: begin src = va; tgt = vb; end
    endcase
  end

  assign key_sel = cmd.probe_fwd ? {src, tgt} : {tgt, src};
  assign he = HE_BITS'({fc, 1'b0}) + HE_BITS'(fc) + HE_BITS'(j);
  assign wdata = cmd.clear_write ? '0 : {epoch, probe_key, he};
  assign {rd_epoch, rd_key, rd_owner} = rdata;

  hetm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (cmd.write_entry | cmd.clear_write),
    .re    (cmd.rd_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
      fc <= '0;
      epoch <= '0;
      addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_face) begin
        va <= corner_a[VERTEX_BITS-1:0];
        vb <= corner_b[VERTEX_BITS-1:0];
        vc <= corner_c[VERTEX_BITS-1:0];
      end
      if (cmd.fc_clear) begin
        fc <= '0;
      end else if (cmd.fc_inc) begin
        fc <= fc + 1'b1;
      end
      if (cmd.j_clear) begin
        j <= '0;
      end else if (cmd.j_inc) begin
        j <= j + 1'b1;
      end
      if (cmd.epoch_init) begin
        epoch <= epoch_t'(1);
      end else if (cmd.epoch_inc) begin
        epoch <= epoch + 1'b1;
      end
      if (cmd.addr_zero) begin
        addr <= '0;
      end else if (cmd.start_probe) begin
        addr <= hash_key(key_sel);
      end else if (cmd.probe_next || cmd.clear_write) begin
        addr <= addr + 1'b1;
      end
      if (cmd.start_probe) begin
        probe_key <= key_sel;
        mode_fwd <= cmd.probe_fwd;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        half_edge_id <= cmd.full_out ? '0 : he;
        opposite_id <= (cmd.opp_sel == OPP_OWNER) ? OPP_BITS'(rd_owner) : '1;
        table_full <= cmd.full_out;
        last <= (j == 2'd2);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.entry_live = (rd_epoch == epoch) && (rd_epoch != '0);
    sts.key_match  = (rd_key == probe_key);
    sts.mode_fwd   = mode_fwd;
    sts.last_j     = (j == 2'd2);
    sts.fc_full    = (fc >= FC_BITS'(MAX_FACES));
    sts.clear_done = (addr == '1);
    sts.epoch_max  = (epoch == '1);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// File: hdl/hetm_ctrl.sv
// controller: sequences table clearing, probes, inserts and result loads
`timescale 1ns / 1ps
`default_nettype none
module hetm_ctrl
  import hetm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      restart,
  input  wire hetm_sts_t sts,
  output hetm_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CHECK,
    S_EMIT_HIT,
    S_EMIT_MISS,
    S_FULL
  } state_t;

  state_t state, state_next;
  logic face_pend, face_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      face_pend <= 1'b0;
    end else begin
      state <= state_next;
      face_pend <= face_pend_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    face_pend_next = face_pend;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (sts.clear_done) begin
          cmd.epoch_init = 1'b1;
          face_pend_next = 1'b0;
          state_next = face_pend ? S_DISPATCH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_face = 1'b1;
          state_next = S_DISPATCH;
          if (restart) begin
            cmd.fc_clear = 1'b1;
            if (sts.epoch_max) begin
              cmd.addr_zero = 1'b1;
              face_pend_next = 1'b1;
              state_next = S_CLEAR;
            end else begin
              cmd.epoch_inc = 1'b1;
            end
          end
        end
      end
      S_DISPATCH: begin
        if (sts.fc_full) begin
          state_next = S_FULL;
        end else begin
          cmd.start_probe = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.entry_live && sts.key_match) begin
          state_next = sts.mode_fwd ? S_EMIT_MISS : S_EMIT_HIT;
        end else if (sts.entry_live) begin
          cmd.probe_next = 1'b1;
          state_next = S_READ;
        end else if (!sts.mode_fwd) begin
          cmd.start_probe = 1'b1;
          cmd.probe_fwd = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.write_entry = 1'b1;
          state_next = S_EMIT_MISS;
        end
      end
      S_EMIT_HIT, S_EMIT_MISS: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.opp_sel = (state == S_EMIT_HIT) ? OPP_OWNER : OPP_NONE;
          if (sts.last_j) begin
            cmd.fc_inc = 1'b1;
            cmd.j_clear = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_next = S_DISPATCH;
          end
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.full_out = 1'b1;
          if (sts.last_j) begin
            cmd.j_clear = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.write_entry |-> !sts.entry_live)
    else $error("insert over a live slot");

  a_hit_live: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.opp_sel == OPP_OWNER) |-> (sts.entry_live && sts.key_match))
    else $error("opposite reported without matching entry");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_write |=> !$past(in_ready))
    else $error("item accepted during clear");

endmodule
`default_nettype wire

// File: hdl/half_edge_twin_matcher_unit.sv
// top level of the half-edge twin matcher
// Each item is one triangle and yields three result items, one per half-edge.
// The edge table is a 4096-slot hashed memory with linear probing; each probe
// is a read followed by a compare, and a half-edge needs one probe chain for the
// reversed edge and on a miss one for its own edge. A result item may wait for
// out_ready. After reset the table is swept before the first item is taken;
// restart clears the face count and only bumps an epoch mark, and every
// fifteenth restart sweeps the table again.
`timescale 1ns / 1ps
`default_nettype none
module half_edge_twin_matcher_unit
  import hetm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CORNER_BITS-1:0] corner_a,
  input  wire logic [CORNER_BITS-1:0] corner_b,
  input  wire logic [CORNER_BITS-1:0] corner_c,
  input  wire logic                   restart,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [HE_BITS-1:0]          half_edge_id,
  output logic signed [OPP_BITS-1:0]  opposite_id,
  output logic                        table_full,
  output logic                        last
);

  hetm_cmd_t cmd;
  hetm_sts_t sts;

  hetm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .sts      (sts),
    .cmd      (cmd)
  );

  hetm_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .half_edge_id (half_edge_id),
    .opposite_id  (opposite_id),
    .table_full   (table_full),
    .last         (last)
  );

endmodule
`default_nettype wire

// File: tb/hetm_checker.sv
// checker: watches both channels, predicts twin pairing and compares results
`timescale 1ns / 1ps
`default_nettype none
module hetm_checker
  import hetm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [CORNER_BITS-1:0] corner_a,
  input  wire logic [CORNER_BITS-1:0] corner_b,
  input  wire logic [CORNER_BITS-1:0] corner_c,
  input  wire logic                   restart,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [HE_BITS-1:0]     half_edge_id,
  input  wire logic signed [OPP_BITS-1:0] opposite_id,
  input  wire logic                   table_full,
  input  wire logic                   last,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen,
  output int                          full_seen,
  output int                          twins_seen
);

  typedef struct packed {
    he_t                 he;
    logic [OPP_BITS-1:0] opp;
    logic                full;
    logic                lst;
  } half_edge_res_t;

  half_edge_res_t twin_queue[$];
  key_t           edge_key[EDGE_DEPTH];
  he_t            edge_who[EDGE_DEPTH];
  int             edge_used;
  int             faces_held;

  function automatic int find_edge(key_t k);
    for (int i = 0; i < edge_used; i++) begin
      if (edge_key[i] == k) return i;
    end
    return -1;
  endfunction

  task automatic predict_face(vertex_t v0, vertex_t v1, vertex_t v2, logic rs);
    vertex_t        cv[3];
    vertex_t        src, tgt;
    int             hit;
    half_edge_res_t r;
    cv[0] = v0; cv[1] = v1; cv[2] = v2;
    if (rs) begin
      edge_used = 0;
      faces_held = 0;
    end
    for (int j = 0; j < 3; j++) begin
      r.lst = (j == 2);
      if (faces_held >= MAX_FACES) begin
        r.he = '0; r.opp = '1; r.full = 1'b1;
      end else begin
        src = cv[(j + 1) % 3];
        tgt = cv[(j + 2) % 3];
        r.he = he_t'(3 * faces_held + j);
        r.full = 1'b0;
        hit = find_edge({tgt, src});
        if (hit >= 0) begin
          r.opp = OPP_BITS'(edge_who[hit]);
        end else begin
          r.opp = '1;
          if (find_edge({src, tgt}) < 0 && edge_used < EDGE_DEPTH) begin
            edge_key[edge_used] = {src, tgt};
            edge_who[edge_used] = r.he;
            edge_used++;
          end
        end
      end
      twin_queue = {twin_queue, r};
    end
    if (faces_held < MAX_FACES) faces_held++;
  endtask

  assign pending = twin_queue.size();

  always @(posedge clk) begin
    half_edge_res_t e;
    if (rst) begin
      edge_used = 0;
      faces_held = 0;
      fail_count <= 0;
      results_seen <= 0;
      full_seen <= 0;
      twins_seen <= 0;
      twin_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (table_full) full_seen <= full_seen + 1;
        if (opposite_id != -1) twins_seen <= twins_seen + 1;
        if (twin_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result he=%0d", half_edge_id);
          fail_count <= fail_count + 1;
        end else begin
          e = twin_queue.pop_front();
          if (e.he !== half_edge_id || e.opp !== opposite_id ||
              e.full !== table_full || e.lst !== last) begin
            if (fail_count < 10)
              $display("mismatch exp he=%0d opp=%0d full=%b last=%b got %0d %0d %b %b",
                       e.he, $signed(e.opp), e.full, e.lst,
                       half_edge_id, opposite_id, table_full, last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_face(corner_a[VERTEX_BITS-1:0], corner_b[VERTEX_BITS-1:0],
                     corner_c[VERTEX_BITS-1:0], restart);
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench top: triangle stimulus, random idling and the final verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import hetm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [CORNER_BITS-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic restart = 1'b0;
  wire logic in_ready, out_valid, table_full, last;
  wire logic [HE_BITS-1:0] half_edge_id;
  wire logic signed [OPP_BITS-1:0] opposite_id;
  int fail_count, pending, results_seen, full_seen, twins_seen;
  int idle_cycles = 0;
  bit calm = 1'b0;
  logic [CORNER_BITS-1:0] vpool[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  half_edge_twin_matcher_unit dut (.*);
  hetm_checker chk (.*);

  always @(posedge clk) begin
    if (in_valid && in_ready) idle_cycles <= 0;
    else if (out_valid && out_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : sink
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_face(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic rs);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    corner_a <= a; corner_b <= b; corner_c <= c; restart <= rs;
    @(posedge clk iff in_ready);
  endtask

  function automatic logic [15:0] pick_vertex();
    if (vpool.size() > 0 && $urandom_range(0, 3) != 0)
      return vpool[$urandom_range(0, vpool.size() - 1)];
    return 16'($urandom());
  endfunction

  initial begin
    logic [15:0] a, b, c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, twins, degenerate, restart
    send_face(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    send_face(16'hFFFF, 16'h0000, 16'h0002, 1'b0);
    send_face(16'h0001, 16'h0000, 16'hFFFF, 1'b0);
    send_face(16'h0005, 16'h0005, 16'h0005, 1'b0);
    send_face(16'h0005, 16'h0005, 16'h0007, 1'b0);
    send_face(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    send_face(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1);
    send_face(16'h5555, 16'hAAAA, 16'h0000, 1'b0);
    send_face(16'h1000, 16'h0001, 16'h1000, 1'b0);
    send_face(16'h0001, 16'h0000, 16'h0002, 1'b0);
    send_face(16'h0002, 16'h0003, 16'h0004, 1'b1);
    // random meshes sharing vertices so twins appear
    for (int i = 0; i < 350; i++) begin
      if (i == 290) calm = 1;
      if (i % 60 == 0) vpool.delete();
      a = pick_vertex(); b = pick_vertex(); c = pick_vertex();
      vpool = {vpool, a, b, c};
      while (vpool.size() > 12) void'(vpool.pop_front());
      send_face(a, b, c, (i % 60 == 0) || ($urandom_range(0, 40) == 0));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("results %0d, twins found %0d, full-table results %0d",
             results_seen, twins_seen, full_seen);
    if (fail_count == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
